// ===== src/cmd_pkg.sv =====
`default_nettype none

package cmd_pkg;

    localparam int MAX_CARS    = 8;
    localparam int CAR_IDX_W   = (MAX_CARS > 1) ? $clog2(MAX_CARS) : 1;
    localparam int CAR_COUNT_W = 4;
    localparam int CYCLE_W     = 31;
    localparam int WORD_W      = 32;
    localparam int BYTE_W      = 8;
    localparam int STATUS_W    = 3;
    localparam int RUN_W       = 3;
    localparam int PAYLOAD_N   = 1 + 4;
    localparam int OUT_W       = STATUS_W + BYTE_W + WORD_W + 1;
    localparam int OUT_PAD_W   = ((OUT_W + 7) / 8) * 8;

    localparam logic [BYTE_W-1:0] BYTE_X    = 8'h58;
    localparam logic [BYTE_W-1:0] BYTE_S    = 8'h53;
    localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'h30;

    localparam logic [RUN_W-1:0] RUN_LEN      = RUN_W'(5);
    localparam logic [RUN_W-1:0] LAST_PAYLOAD = RUN_W'(PAYLOAD_N - 1);

    localparam logic [CYCLE_W-1:0] INF_BITS      = 31'h7F80_0000;
    localparam logic [WORD_W-1:0]  NEG_ZERO_BITS = 32'h8000_0000;

    localparam logic [STATUS_W-1:0] ST_SPEED_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SPEED_ZEROED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REQ_STORED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OLD_CYCLE    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FUTURE_CYCLE = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BAD_CAR      = 3'd5;

    localparam logic [1:0] CFG_CAR_COUNT     = 2'd0;
    localparam logic [1:0] CFG_CURRENT_CYCLE = 2'd1;
    localparam logic [1:0] CFG_MAX_SPEED     = 2'd2;

    typedef enum logic [1:0] {
        SYM_OTHER = 2'd0,
        SYM_X     = 2'd1,
        SYM_S     = 2'd2
    } sym_t;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'b001,
        MODE_SPEED  = 3'b010,
        MODE_VERIFY = 3'b100
    } mode_t;

    // table update from a completed message
    typedef struct packed {
        logic                 speed_we;
        logic                 request_we;
        logic [CAR_IDX_W-1:0] car;
        logic [CYCLE_W-1:0]   cycle;
    } tbl_wr_t;

    function automatic logic [CAR_COUNT_W-1:0] active_cars(
        input logic [CAR_COUNT_W-1:0] n
    );
        return (int'(n) > MAX_CARS) ? CAR_COUNT_W'(MAX_CARS) : n;
    endfunction

endpackage

`default_nettype wire

// ===== src/cmd_car_table.sv =====
`default_nettype none

module cmd_car_table
    import cmd_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire tbl_wr_t                wr,
    input  wire logic [CAR_COUNT_W-1:0] car_count,
    input  wire logic [CYCLE_W-1:0]     current_cycle,
    output logic                        ready_next
);

    // a written speed is always non-negative, so one bit per car suffices
    logic [MAX_CARS-1:0] speed_set_reg;
    logic [MAX_CARS-1:0] speed_set_next;
    logic [CYCLE_W-1:0]  request_reg  [MAX_CARS];
    logic [CYCLE_W-1:0]  request_next [MAX_CARS];
    logic [CAR_COUNT_W-1:0] active;

    always_comb begin
        speed_set_next = speed_set_reg;
        request_next   = request_reg;
        if (wr.speed_we) begin
            speed_set_next[wr.car] = 1'b1;
        end
        if (wr.request_we) begin
            request_next[wr.car] = wr.cycle;
        end
    end

    // flag reflects the tables after this message's update
    always_comb begin
        active     = active_cars(car_count);
        ready_next = 1'b1;
        for (int i = 0; i < MAX_CARS; i++) begin
            if (CAR_COUNT_W'(i) < active) begin
                if (!speed_set_next[i] || request_next[i] != current_cycle) begin
                    ready_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_set_reg <= '0;
            for (int i = 0; i < MAX_CARS; i++) begin
                request_reg[i] <= '0;
            end
        end else begin
            speed_set_reg <= speed_set_next;
            request_reg   <= request_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/car_message_deframer.sv =====
`default_nettype none

// Car radio link deframer. Takes one link byte per cycle on s_*; while idle a
// run of five 'X' (speed) or five 'S' (verify) bytes opens a message, other
// bytes leave the run counts and last-symbol mark untouched. The five payload
// bytes (ASCII car digit, then a little-endian 32-bit word) yield one result
// on m_* in the cycle after the last byte is taken; all other bytes yield none.
// Sustained rate is one byte per cycle: a single output register sits between
// the decode logic and m_*, and a new byte is taken whenever that register is
// empty or being drained. Configuration writes on cfg_* are always taken and
// should only be issued while no message is in flight. No clearing pass is
// needed after reset.
module car_message_deframer
    import cmd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // [7:0] rx_byte

    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [2:0] status, [10:3] car_index, [42:11] payload_word,
    // [43] ready_to_verify, [47:44] zero
    output logic [OUT_PAD_W-1:0]      m_tdata,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [CYCLE_W-1:0]   cfg_data
);

    logic [CAR_COUNT_W-1:0] car_count_reg;
    logic [CYCLE_W-1:0]     current_cycle_reg;
    logic [CYCLE_W-1:0]     max_speed_reg;

    sym_t                   prev_sym_reg,  prev_sym_next;
    mode_t                  mode_reg,      mode_next;
    logic [RUN_W-1:0]       speed_run_reg, speed_run_next;
    logic [RUN_W-1:0]       verify_run_reg, verify_run_next;
    logic [RUN_W-1:0]       count_reg,     count_next;
    logic [BYTE_W-1:0]      payload_reg [PAYLOAD_N-1];

    logic                   m_tvalid_reg,  m_tvalid_next;
    logic [OUT_PAD_W-1:0]   m_tdata_reg,   m_tdata_next;

    logic                   accept;
    logic                   done;
    logic [RUN_W-1:0]       run_inc;
    logic [BYTE_W-1:0]      car;
    logic [WORD_W-1:0]      word;
    logic [WORD_W-1:0]      word_out;
    logic [STATUS_W-1:0]    status;
    logic                   bad_car;
    logic                   speed_ok;
    tbl_wr_t                tbl_wr;
    logic                   ready_next;

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // message fields; the last word byte is the one arriving now
    assign car  = payload_reg[0] - BYTE_ZERO;
    assign word = {s_tdata, payload_reg[3], payload_reg[2], payload_reg[1]};
    assign done = accept && mode_reg != MODE_IDLE && count_reg == LAST_PAYLOAD;

    always_comb begin
        bad_car  = car >= BYTE_W'(active_cars(car_count_reg));
        speed_ok = (word == NEG_ZERO_BITS || word <= {1'b0, INF_BITS})
                   && max_speed_reg <= INF_BITS
                   && word[CYCLE_W-1:0] <= max_speed_reg;

        tbl_wr.speed_we   = 1'b0;
        tbl_wr.request_we = 1'b0;
        tbl_wr.car        = car[CAR_IDX_W-1:0];
        tbl_wr.cycle      = word[CYCLE_W-1:0];
        word_out          = word;

        if (bad_car) begin
            status = ST_BAD_CAR;
        end else if (mode_reg == MODE_SPEED) begin
            tbl_wr.speed_we = done;
            if (speed_ok) begin
                status = ST_SPEED_OK;
            end else begin
                status   = ST_SPEED_ZEROED;
                word_out = '0;
            end
        end else if (!word[WORD_W-1] && word[CYCLE_W-1:0] == current_cycle_reg) begin
            tbl_wr.request_we = done;
            status            = ST_REQ_STORED;
        end else if (word[WORD_W-1] || word[CYCLE_W-1:0] < current_cycle_reg) begin
            status = ST_OLD_CYCLE;
        end else begin
            status = ST_FUTURE_CYCLE;
        end
    end

    cmd_car_table u_table (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .wr            (tbl_wr),
        .car_count     (car_count_reg),
        .current_cycle (current_cycle_reg),
        .ready_next    (ready_next)
    );

    always_comb begin
        prev_sym_next   = prev_sym_reg;
        mode_next       = mode_reg;
        speed_run_next  = speed_run_reg;
        verify_run_next = verify_run_reg;
        count_next      = count_reg;
        run_inc         = '0;

        if (accept) begin
            case (mode_reg)
                MODE_IDLE: begin
                    if (s_tdata == BYTE_X) begin
                        run_inc       = (prev_sym_reg == SYM_X) ? speed_run_reg + 1'b1
                                                                : RUN_W'(1);
                        prev_sym_next = SYM_X;
                        if (run_inc >= RUN_LEN) begin
                            speed_run_next = '0;
                            count_next     = '0;
                            mode_next      = MODE_SPEED;
                        end else begin
                            speed_run_next = run_inc;
                        end
                    end else if (s_tdata == BYTE_S) begin
                        run_inc       = (prev_sym_reg == SYM_S) ? verify_run_reg + 1'b1
                                                                : RUN_W'(1);
                        prev_sym_next = SYM_S;
                        if (run_inc >= RUN_LEN) begin
                            verify_run_next = '0;
                            count_next      = '0;
                            mode_next       = MODE_VERIFY;
                        end else begin
                            verify_run_next = run_inc;
                        end
                    end
                end
                MODE_SPEED, MODE_VERIFY: begin
                    prev_sym_next = SYM_OTHER;
                    if (count_reg == LAST_PAYLOAD) begin
                        count_next = '0;
                        mode_next  = MODE_IDLE;
                    end else begin
                        count_next = count_reg + 1'b1;
                    end
                end
                default: begin
                    mode_next = MODE_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        if (done) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {(OUT_PAD_W - OUT_W)'(0), ready_next, word_out, car, status};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            car_count_reg     <= CAR_COUNT_W'(2);
            current_cycle_reg <= '0;
            max_speed_reg     <= CYCLE_W'(1120403456);
            prev_sym_reg      <= SYM_OTHER;
            mode_reg          <= MODE_IDLE;
            speed_run_reg     <= '0;
            verify_run_reg    <= '0;
            count_reg         <= '0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_CAR_COUNT:     car_count_reg     <= cfg_data[CAR_COUNT_W-1:0];
                    CFG_CURRENT_CYCLE: current_cycle_reg <= cfg_data;
                    CFG_MAX_SPEED:     max_speed_reg     <= cfg_data;
                    default: ;
                endcase
            end
            prev_sym_reg   <= prev_sym_next;
            mode_reg       <= mode_next;
            speed_run_reg  <= speed_run_next;
            verify_run_reg <= verify_run_next;
            count_reg      <= count_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // payload bytes and result data carry no reset
    always_ff @(posedge aclk) begin
        if (accept && mode_reg != MODE_IDLE && count_reg != LAST_PAYLOAD) begin
            payload_reg[count_reg[$clog2(PAYLOAD_N-1)-1:0]] <= s_tdata;
        end
        m_tdata_reg <= m_tdata_next;
    end

endmodule

`default_nettype wire

// ===== tb/sv/car_message_deframer_tb.sv =====
`default_nettype none

module car_message_deframer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cmd_pkg::*;

    localparam int RAND_BYTES = 1480;
    localparam int CALM_TAIL  = 150;
    localparam int SETTLE     = 4;
    localparam int LIMIT      = 400000;

    localparam logic [WORD_W-1:0] NEG_ONE_BITS = 32'hBF80_0000;
    localparam logic [1:0]        CFG_UNUSED   = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   car;
        logic [WORD_W-1:0]   word;
        logic                rdy;
    } frame_result_t;

    typedef enum {ROW_CFG, ROW_MSG} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic [1:0]         idx;
        logic [CYCLE_W-1:0] data;
        logic [BYTE_W-1:0]  hdr;
        logic [BYTE_W-1:0]  car;
        logic [WORD_W-1:0]  word;
        int                 gap_at;
        logic [BYTE_W-1:0]  gap_byte;
        bit                 typed;
        frame_result_t      want;
    } plan_row_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;   // [7:0] rx_byte
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    // [2:0] status, [10:3] car_index, [42:11] payload_word,
    // [43] ready_to_verify, [47:44] zero
    logic [OUT_PAD_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [1:0]           cfg_index = '0;
    logic [CYCLE_W-1:0]   cfg_data  = '0;

    // deframer shadow: configuration, framing state and tables
    logic [CAR_COUNT_W-1:0] cur_cars;
    logic [CYCLE_W-1:0]     cur_cycle;
    logic [CYCLE_W-1:0]     cur_max;
    sym_t                   last_sym;
    int                     x_run;
    int                     s_run;
    mode_t                  fmode;
    int                     pay_cnt;
    logic [BYTE_W-1:0]      pay_buf [PAYLOAD_N];
    logic [WORD_W-1:0]      speed_tab [MAX_CARS];
    logic [WORD_W-1:0]      req_tab [MAX_CARS];

    frame_result_t pending_results[$];
    bit            want_given = 1'b0;
    frame_result_t want_next;

    int errors     = 0;
    int bytes_sent = 0;
    int cycle_cnt  = 0;
    int gap_odds   = 0;
    int stall_odds = 0;
    int stall_left = 0;
    bit calm       = 1'b0;

    car_message_deframer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        while (cycle_cnt < LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("TB_ERROR");
        $finish;
    end

    function automatic bit non_negative(input logic [WORD_W-1:0] w);
        return (w == NEG_ZERO_BITS) || (w <= {1'b0, INF_BITS});
    endfunction

    function automatic bit speed_in_range(input logic [WORD_W-1:0] w);
        if (!non_negative(w))
            return 1'b0;
        if (cur_max > INF_BITS)
            return 1'b0;
        return w[WORD_W-2:0] <= cur_max;
    endfunction

    function automatic int cars_in_use();
        return (int'(cur_cars) > MAX_CARS) ? MAX_CARS : int'(cur_cars);
    endfunction

    function automatic logic ready_now();
        for (int i = 0; i < cars_in_use(); i++) begin
            if (!non_negative(speed_tab[i]) || req_tab[i] != {1'b0, cur_cycle})
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic plan_row_t msg_row(
        input logic [BYTE_W-1:0] hdr, input logic [BYTE_W-1:0] car,
        input logic [WORD_W-1:0] word, input bit typed,
        input logic [STATUS_W-1:0] st, input logic [BYTE_W-1:0] ci,
        input logic [WORD_W-1:0] wd, input logic rdy
    );
        plan_row_t r;
        r.kind        = ROW_MSG;
        r.idx         = '0;
        r.data        = '0;
        r.hdr         = hdr;
        r.car         = car;
        r.word        = word;
        r.gap_at      = -1;
        r.gap_byte    = '0;
        r.typed       = typed;
        r.want.status = st;
        r.want.car    = ci;
        r.want.word   = wd;
        r.want.rdy    = rdy;
        return r;
    endfunction

    function automatic plan_row_t cfg_row(input logic [1:0] idx, input logic [CYCLE_W-1:0] v);
        plan_row_t r;
        r      = msg_row('0, '0, '0, 1'b0, '0, '0, '0, 1'b0);
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.data = v;
        return r;
    endfunction

    // advances the shadow by one accepted byte; queues a result when a message closes
    task automatic track_link_byte(input logic [BYTE_W-1:0] b);
        frame_result_t r;
        logic [BYTE_W-1:0] car;
        logic [WORD_W-1:0] word;
        if (fmode == MODE_IDLE) begin
            // other bytes leave both runs and the last-symbol mark alone
            if (b == BYTE_X) begin
                x_run    = (last_sym == SYM_X) ? x_run + 1 : 1;
                last_sym = SYM_X;
                if (x_run >= RUN_LEN) begin
                    x_run   = 0;
                    pay_cnt = 0;
                    fmode   = MODE_SPEED;
                end
            end else if (b == BYTE_S) begin
                s_run    = (last_sym == SYM_S) ? s_run + 1 : 1;
                last_sym = SYM_S;
                if (s_run >= RUN_LEN) begin
                    s_run   = 0;
                    pay_cnt = 0;
                    fmode   = MODE_VERIFY;
                end
            end
            return;
        end
        last_sym = SYM_OTHER;
        if (pay_cnt >= PAYLOAD_N)
            pay_cnt = 0;
        pay_buf[pay_cnt[$clog2(PAYLOAD_N)-1:0]] = b;
        pay_cnt++;
        if (pay_cnt < PAYLOAD_N)
            return;
        car  = pay_buf[0] - BYTE_ZERO;
        word = {pay_buf[4], pay_buf[3], pay_buf[2], pay_buf[1]};
        if (int'(car) >= cars_in_use()) begin
            r.status = ST_BAD_CAR;
        end else if (fmode == MODE_SPEED) begin
            if (speed_in_range(word)) begin
                r.status = ST_SPEED_OK;
            end else begin
                r.status = ST_SPEED_ZEROED;
                word     = '0;
            end
            speed_tab[car[CAR_IDX_W-1:0]] = word;
        end else if (!word[WORD_W-1] && word == {1'b0, cur_cycle}) begin
            req_tab[car[CAR_IDX_W-1:0]] = word;
            r.status     = ST_REQ_STORED;
        end else if (word[WORD_W-1] || word < {1'b0, cur_cycle}) begin
            r.status = ST_OLD_CYCLE;
        end else begin
            r.status = ST_FUTURE_CYCLE;
        end
        fmode   = MODE_IDLE;
        pay_cnt = 0;
        r.car   = car;
        r.word  = word;
        r.rdy   = ready_now();
        if (want_given) begin
            pending_results = {pending_results, want_next};
            want_given = 1'b0;
        end else begin
            pending_results = {pending_results, r};
        end
    endtask

    // one byte request; entered and left at a falling edge
    task automatic send_rx(input logic [BYTE_W-1:0] b);
        if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        track_link_byte(b);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [CYCLE_W-1:0] v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        case (idx)
            CFG_CAR_COUNT:     cur_cars  = v[CAR_COUNT_W-1:0];
            CFG_CURRENT_CYCLE: cur_cycle = v;
            CFG_MAX_SPEED:     cur_max   = v;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_config();
        logic [CYCLE_W-1:0] v;
        // close any frame left open by a cut-short message first
        while (fmode != MODE_IDLE)
            send_rx(BYTE_W'($urandom_range(0, 255)));
        drain_results();
        case ($urandom_range(0, 7))
            0:       v = '0;
            1:       v = CYCLE_W'(15);
            2:       v = CYCLE_W'(MAX_CARS);
            3:       v = CYCLE_W'(1);
            default: v = CYCLE_W'($urandom_range(1, MAX_CARS));
        endcase
        if ($urandom_range(0, 3) == 0)
            v[CYCLE_W-1:CAR_COUNT_W] = (CYCLE_W - CAR_COUNT_W)'($urandom);
        write_cfg(CFG_CAR_COUNT, v);
        case ($urandom_range(0, 5))
            0:       v = '0;
            1:       v = 31'h7FFF_FFFF;
            2:       v = CYCLE_W'($urandom_range(0, 15));
            default: v = CYCLE_W'($urandom);
        endcase
        write_cfg(CFG_CURRENT_CYCLE, v);
        case ($urandom_range(0, 7))
            0:       v = '0;
            1:       v = 31'h42C8_0000;
            2:       v = INF_BITS;
            3:       v = 31'h7FFF_FFFF;
            4:       v = INF_BITS + 1'b1;
            default: v = CYCLE_W'($urandom_range(0, int'(INF_BITS)));
        endcase
        write_cfg(CFG_MAX_SPEED, v);
        if ($urandom_range(0, 5) == 0)
            write_cfg(CFG_UNUSED, CYCLE_W'($urandom));
    endtask

    task automatic random_message();
        logic [BYTE_W-1:0] seq[$];
        logic [BYTE_W-1:0] hdr;
        logic [BYTE_W-1:0] nz;
        logic [BYTE_W-1:0] car;
        logic [WORD_W-1:0] word;
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick >= 92) begin
            // loose line noise
            repeat ($urandom_range(1, 6)) send_rx(BYTE_W'($urandom_range(0, 255)));
            return;
        end
        hdr = (pick < 46) ? BYTE_X : BYTE_S;
        for (int i = 0; i < RUN_LEN; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                do begin
                    nz = BYTE_W'($urandom_range(0, 255));
                end while (nz == BYTE_X || nz == BYTE_S);
                seq = {seq, nz};
            end
            seq = {seq, hdr};
        end
        // broken header: one symbol swapped for the other kind
        if ($urandom_range(0, 11) == 0)
            seq[$urandom_range(0, seq.size() - 1)] = (hdr == BYTE_X) ? BYTE_S : BYTE_X;
        pick = $urandom_range(0, 19);
        if (pick < 12)
            car = BYTE_ZERO + BYTE_W'($urandom_range(0, (cars_in_use() > 0) ? cars_in_use() - 1 : 0));
        else if (pick < 17)
            car = BYTE_ZERO + BYTE_W'($urandom_range(0, 9));
        else
            car = BYTE_W'($urandom_range(0, 255));
        seq = {seq, car};
        if (hdr == BYTE_X) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: word = WORD_W'($urandom_range(0, int'(cur_max)));
                4:          word = {1'b0, cur_max};
                5:          word = {1'b0, cur_max} + 1'b1;
                6:          word = NEG_ZERO_BITS;
                7:          word = NEG_ZERO_BITS | $urandom;
                8:          word = {1'b0, INF_BITS} | WORD_W'($urandom_range(0, 32'h7F_FFFF));
                default:    word = $urandom;
            endcase
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: word = {1'b0, cur_cycle};
                4:          word = {1'b0, cur_cycle} - 1'b1;
                5:          word = {1'b0, cur_cycle} + 1'b1;
                6:          word = NEG_ZERO_BITS | $urandom;
                7:          word = '0;
                default:    word = $urandom;
            endcase
        end
        for (int k = 0; k < 4; k++)
            seq = {seq, word[8*k +: 8]};
        n = seq.size();
        // now and then cut the frame short so the next one lands mid-payload
        if ($urandom_range(0, 15) == 0)
            n = $urandom_range(1, seq.size() - 1);
        for (int i = 0; i < n; i++)
            send_rx(seq[i]);
    endtask

    always @(negedge aclk) begin
        if (!calm && stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            stall_left = $urandom_range(0, 8);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        frame_result_t got;
        frame_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = m_tdata[STATUS_W-1:0];
            got.car    = m_tdata[STATUS_W +: BYTE_W];
            got.word   = m_tdata[STATUS_W+BYTE_W +: WORD_W];
            got.rdy    = m_tdata[STATUS_W+BYTE_W+WORD_W];
            if (pending_results.size() == 0) begin
                $display("%0t: result with none expected: status %0d car %0h word %h ready %0b",
                         $time, got.status, got.car, got.word, got.rdy);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status) begin
                    $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
                    errors++;
                end
                if (got.car !== want.car) begin
                    $display("%0t: car_index expected %0h got %0h", $time, want.car, got.car);
                    errors++;
                end
                if (got.word !== want.word) begin
                    $display("%0t: payload_word expected %h got %h", $time, want.word, got.word);
                    errors++;
                end
                if (got.rdy !== want.rdy) begin
                    $display("%0t: ready_to_verify expected %0b got %0b", $time, want.rdy, got.rdy);
                    errors++;
                end
            end
        end
    end

    initial begin
        plan_row_t plan[$];
        plan_row_t r;
        int rand_start;
        int next_cfg;

        cur_cars  = CAR_COUNT_W'(2);
        cur_cycle = '0;
        cur_max   = 31'h42C8_0000;
        last_sym  = SYM_OTHER;
        x_run     = 0;
        s_run     = 0;
        fmode     = MODE_IDLE;
        pay_cnt   = 0;
        for (int i = 0; i < MAX_CARS; i++) begin
            speed_tab[i] = NEG_ONE_BITS;
            req_tab[i]   = '0;
        end
        for (int i = 0; i < PAYLOAD_N; i++)
            pay_buf[i] = '0;

        // reset settings: two cars, cycle 0, limit 100.0
        plan = {plan, msg_row(BYTE_X, BYTE_ZERO, 32'h42C8_0000, 1'b1,
                              ST_SPEED_OK, 8'd0, 32'h42C8_0000, 1'b0)};
        plan = {plan, msg_row(BYTE_X, BYTE_ZERO + 8'd1, 32'h0000_0000, 1'b1,
                              ST_SPEED_OK, 8'd1, 32'h0000_0000, 1'b1)};
        plan = {plan, msg_row(BYTE_X, BYTE_ZERO + 8'd1, 32'h42C8_0001, 1'b1,
                              ST_SPEED_ZEROED, 8'd1, 32'h0000_0000, 1'b1)};
        plan = {plan, msg_row(BYTE_X, BYTE_ZERO, NEG_ZERO_BITS, 1'b1,
                              ST_SPEED_OK, 8'd0, NEG_ZERO_BITS, 1'b1)};
        plan = {plan, msg_row(BYTE_X, BYTE_ZERO, NEG_ONE_BITS, 1'b1,
                              ST_SPEED_ZEROED, 8'd0, 32'h0000_0000, 1'b1)};
        plan = {plan, msg_row(BYTE_X, BYTE_ZERO + 8'd2, 32'h1234_5678, 1'b1,
                              ST_BAD_CAR, 8'd2, 32'h1234_5678, 1'b1)};
        plan = {plan, msg_row(BYTE_S, BYTE_ZERO, 32'h0000_0000, 1'b1,
                              ST_REQ_STORED, 8'd0, 32'h0000_0000, 1'b1)};
        plan = {plan, msg_row(BYTE_S, BYTE_ZERO + 8'd1, NEG_ZERO_BITS, 1'b1,
                              ST_OLD_CYCLE, 8'd1, NEG_ZERO_BITS, 1'b1)};
        plan = {plan, msg_row(BYTE_S, BYTE_ZERO + 8'd1, 32'h0000_0001, 1'b1,
                              ST_FUTURE_CYCLE, 8'd1, 32'h0000_0001, 1'b1)};
        plan = {plan, msg_row(BYTE_X, 8'hFF, 32'h7FC0_0000, 1'b1,
                              ST_BAD_CAR, 8'hCF, 32'h7FC0_0000, 1'b1)};
        // a stray byte inside the header run must not restart it
        r = msg_row(BYTE_X, BYTE_ZERO - 8'd1, 32'hFFFF_FFFF, 1'b1,
                    ST_BAD_CAR, 8'hFF, 32'hFFFF_FFFF, 1'b1);
        r.gap_at   = 2;
        r.gap_byte = 8'h41;
        plan = {plan, r};
        plan = {plan, cfg_row(CFG_CURRENT_CYCLE, 31'h7FFF_FFFF)};
        plan = {plan, msg_row(BYTE_S, BYTE_ZERO, 32'h7FFF_FFFF, 1'b1,
                              ST_REQ_STORED, 8'd0, 32'h7FFF_FFFF, 1'b0)};
        plan = {plan, msg_row(BYTE_S, BYTE_ZERO + 8'd1, 32'h7FFF_FFFF, 1'b1,
                              ST_REQ_STORED, 8'd1, 32'h7FFF_FFFF, 1'b1)};
        plan = {plan, cfg_row(CFG_MAX_SPEED, INF_BITS)};
        plan = {plan, msg_row(BYTE_X, BYTE_ZERO, 32'h7F80_0000, 1'b1,
                              ST_SPEED_OK, 8'd0, 32'h7F80_0000, 1'b1)};
        plan = {plan, msg_row(BYTE_X, BYTE_ZERO, 32'h7F80_0001, 1'b1,
                              ST_SPEED_ZEROED, 8'd0, 32'h0000_0000, 1'b1)};
        // a NaN limit rejects every speed
        plan = {plan, cfg_row(CFG_MAX_SPEED, 31'h7FFF_FFFF)};
        plan = {plan, msg_row(BYTE_X, BYTE_ZERO + 8'd1, 32'h0000_0000, 1'b1,
                              ST_SPEED_ZEROED, 8'd1, 32'h0000_0000, 1'b1)};
        plan = {plan, cfg_row(CFG_MAX_SPEED, '0)};
        plan = {plan, msg_row(BYTE_X, BYTE_ZERO + 8'd1, NEG_ZERO_BITS, 1'b1,
                              ST_SPEED_OK, 8'd1, NEG_ZERO_BITS, 1'b1)};
        plan = {plan, cfg_row(CFG_CAR_COUNT, '0)};
        plan = {plan, msg_row(BYTE_S, BYTE_ZERO, 32'h0000_0000, 1'b1,
                              ST_BAD_CAR, 8'd0, 32'h0000_0000, 1'b1)};
        // upper bits dropped, fifteen clamps to the full car set
        plan = {plan, cfg_row(CFG_CAR_COUNT, 31'h7FFF_FFFF)};
        plan = {plan, msg_row(BYTE_X, BYTE_ZERO + 8'd7, 32'h0000_0000, 1'b1,
                              ST_SPEED_OK, 8'd7, 32'h0000_0000, 1'b0)};
        plan = {plan, msg_row(BYTE_X, BYTE_ZERO + 8'd9, 32'h0000_0005, 1'b1,
                              ST_BAD_CAR, 8'd9, 32'h0000_0005, 1'b0)};
        plan = {plan, cfg_row(CFG_CAR_COUNT, CYCLE_W'(1))};
        plan = {plan, msg_row(BYTE_S, BYTE_ZERO, 32'h7FFF_FFFF, 1'b0, '0, '0, '0, 1'b0)};
        r = msg_row(BYTE_X, BYTE_ZERO, 32'h3F80_0000, 1'b0, '0, '0, '0, 1'b0);
        r.gap_at   = 4;
        r.gap_byte = 8'h00;
        plan = {plan, r};

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        gap_odds   = 4;
        stall_odds = 4;
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) begin
                drain_results();
                write_cfg(plan[i].idx, plan[i].data);
            end else begin
                want_given = plan[i].typed;
                want_next  = plan[i].want;
                for (int h = 0; h < RUN_LEN; h++) begin
                    if (h == plan[i].gap_at)
                        send_rx(plan[i].gap_byte);
                    send_rx(plan[i].hdr);
                end
                send_rx(plan[i].car);
                for (int k = 0; k < 4; k++)
                    send_rx(plan[i].word[8*k +: 8]);
                want_given = 1'b0;
            end
        end

        rand_start = bytes_sent;
        next_cfg   = 0;
        while (bytes_sent - rand_start < RAND_BYTES) begin
            if (bytes_sent - rand_start >= next_cfg) begin
                random_config();
                gap_odds   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
                stall_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
                next_cfg  += $urandom_range(200, 320);
            end
            calm = (bytes_sent - rand_start >= RAND_BYTES - CALM_TAIL);
            random_message();
        end

        drain_results();
        repeat (8) @(posedge aclk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
